FILE: rtl/co2_sensor_frame_decoder_assert.svh
// Assertion macros for the CO2 sensor frame decoder.
`ifndef CO2_SENSOR_FRAME_DECODER_ASSERT_SVH
`define CO2_SENSOR_FRAME_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CO2SFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("co2sfd: same-cycle check failed");
`define CO2SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("co2sfd: next-cycle check failed");
`else
`define CO2SFD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CO2SFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/co2sfd_pkg.sv
// Shared types, constants and CRC function for the CO2 sensor frame decoder.
`timescale 1ns / 1ps
package co2sfd_pkg;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_MEAS   = 1'b1
  } frame_kind_t;

  localparam int unsigned POS_W = 4;

  localparam logic [POS_W-1:0] STATUS_LEN = 4'd3;
  localparam logic [POS_W-1:0] MEAS_LEN   = 4'd9;

  localparam logic [POS_W-1:0] POS_HIGH0 = 4'd0;
  localparam logic [POS_W-1:0] POS_HIGH1 = 4'd3;
  localparam logic [POS_W-1:0] POS_HIGH2 = 4'd6;
  localparam logic [POS_W-1:0] POS_CRC0  = 4'd2;
  localparam logic [POS_W-1:0] POS_CRC1  = 4'd5;
  localparam logic [POS_W-1:0] POS_CRC2  = 4'd8;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [10:0] STATUS_MASK = 11'h7FF;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  typedef struct packed {
    logic        done;
    frame_kind_t kind;
    logic        ok;
    logic        ready;
    logic [15:0] co2;
    logic [15:0] tword;
    logic [15:0] hword;
  } rec_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/co2sfd_parse.sv
// Byte framing, per-word CRC check and word capture for the frame decoder.
`timescale 1ns / 1ps
module co2sfd_parse import co2sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic       mode,
  input  logic       frame_start,
  input  logic [7:0] rx_byte,
  output rec_t       rec
);

  logic [POS_W-1:0] byte_position;
  frame_kind_t      frame_type;
  logic [7:0]       running_crc;
  logic [7:0]       high_byte;
  logic [7:0]       low_byte;
  logic [15:0]      first_word;
  logic [15:0]      second_word;
  logic             crc_failed;

  frame_kind_t      ft;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] len;
  logic [7:0]       crc_cur;
  logic [7:0]       crc_upd;
  logic             failed_cur;
  logic             active;
  logic             is_crc;
  logic             is_high;
  logic             crc_bad;
  logic [15:0]      word;

  always_comb begin
    ft         = frame_start ? frame_kind_t'(mode) : frame_type;
    pos        = frame_start ? '0 : byte_position;
    crc_cur    = frame_start ? CRC_INIT : running_crc;
    failed_cur = frame_start ? 1'b0 : crc_failed;
    len        = (ft == KIND_MEAS) ? MEAS_LEN : STATUS_LEN;
    pos_inc    = pos + 4'd1;
    active     = pos < len;
    is_crc     = (pos == POS_CRC0) || (pos == POS_CRC1) || (pos == POS_CRC2);
    is_high    = (pos == POS_HIGH0) || (pos == POS_HIGH1) || (pos == POS_HIGH2);
    crc_upd    = crc8_byte(crc_cur, rx_byte);
    crc_bad    = crc_cur != rx_byte;
    word       = {high_byte, low_byte};

    rec.done  = active && is_crc && (pos_inc == len);
    rec.kind  = ft;
    rec.ok    = !(failed_cur || crc_bad);
    if (ft == KIND_MEAS) begin
      rec.ready = rec.ok;
      rec.co2   = first_word;
    end else begin
      rec.ready = rec.ok && (word[10:0] & STATUS_MASK) != '0;
      rec.co2   = '0;
    end
    rec.tword = second_word;
    rec.hword = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_type    <= KIND_STATUS;
      running_crc   <= CRC_INIT;
      high_byte     <= '0;
      low_byte      <= '0;
      first_word    <= '0;
      second_word   <= '0;
      crc_failed    <= 1'b0;
    end else if (acc) begin
      if (frame_start) begin
        frame_type <= frame_kind_t'(mode);
      end
      if (active) begin
        byte_position <= pos_inc;
        if (is_crc) begin
          running_crc <= CRC_INIT;
          crc_failed  <= failed_cur || crc_bad;
          if (pos == POS_CRC0) begin
            first_word <= word;
          end
          if (pos == POS_CRC1) begin
            second_word <= word;
          end
        end else begin
          running_crc <= crc_upd;
          crc_failed  <= failed_cur;
          if (is_high) begin
            high_byte <= rx_byte;
          end else begin
            low_byte <= rx_byte;
          end
        end
      end
    end
  end

endmodule

FILE: rtl/co2_sensor_frame_decoder.sv
// Top level of the CO2 sensor frame decoder: framing, scaling and result pipeline.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  byte     | byte_valid / byte_stall    | mode, frame_start, rx_byte
//  result   | result_valid / result_stall| frame_kind, crc_ok, data_ready, co2_ppm,
//           |                            | temperature_centi, humidity_centi
//
//  One byte per cycle while byte_stall is low; a result passes the record, product and
//  output registers in turn before it shows on result_valid.
//  Reset is synchronous: the pipeline empties and framing restarts as a status frame.
//  byte_stall rises only when all three result registers hold transactions and
//  result_stall is high.
`timescale 1ns / 1ps
module co2_sensor_frame_decoder import co2sfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic               mode,
  input  logic               frame_start,
  input  logic [7:0]         rx_byte,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               frame_kind,
  output logic               crc_ok,
  output logic               data_ready,
  output logic [15:0]        co2_ppm,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi
);

`include "co2_sensor_frame_decoder_assert.svh"

  rec_t        parse_rec;
  rec_t        rec;
  logic        rec_valid;
  logic        byte_acc;
  logic        o_free;
  logic        p_free;
  logic        r_free;

  logic        p_valid;
  frame_kind_t p_kind;
  logic        p_ok;
  logic        p_ready;
  logic [15:0] p_co2;
  logic [30:0] p_tprod;
  logic [29:0] p_hprod;

  logic [31:0] t_sum;
  logic [30:0] h_sum;
  logic [14:0] t_val;
  logic [13:0] h_val;

  assign o_free     = !result_valid || !result_stall;
  assign p_free     = !p_valid || o_free;
  assign r_free     = !rec_valid || p_free;
  assign byte_stall = !r_free;
  assign byte_acc   = byte_valid && !byte_stall;

  co2sfd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .acc         (byte_acc),
    .mode        (mode),
    .frame_start (frame_start),
    .rx_byte     (rx_byte),
    .rec         (parse_rec)
  );

  always_comb begin
    t_sum = {1'b0, p_tprod} + {17'b0, p_tprod[30:16]} + 32'd1;
    h_sum = {1'b0, p_hprod} + {17'b0, p_hprod[29:16]} + 31'd1;
    t_val = t_sum[30:16] - TEMP_OFFSET;
    h_val = h_sum[29:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid    <= 1'b0;
      p_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (r_free) begin
        rec_valid <= byte_acc && parse_rec.done;
      end
      if (p_free) begin
        p_valid <= rec_valid;
      end
      if (o_free) begin
        result_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_free && byte_acc) begin
      rec <= parse_rec;
    end
    if (p_free && rec_valid) begin
      p_kind  <= rec.kind;
      p_ok    <= rec.ok;
      p_ready <= rec.ready;
      p_co2   <= rec.co2;
      p_tprod <= {16'b0, TEMP_SCALE} * {15'b0, rec.tword};
      p_hprod <= {16'b0, HUM_SCALE} * {14'b0, rec.hword};
    end
    if (o_free && p_valid) begin
      frame_kind <= p_kind;
      crc_ok     <= p_ok;
      data_ready <= p_ready;
      co2_ppm    <= p_co2;
      if (p_kind == KIND_MEAS) begin
        temperature_centi <= $signed(t_val);
        humidity_centi    <= h_val;
      end else begin
        temperature_centi <= '0;
        humidity_centi    <= '0;
      end
    end
  end

  `CO2SFD_ASSERT_IMPL(a_stall_full, clk, rst, byte_stall,
                      rec_valid && p_valid && result_valid && result_stall)
  `CO2SFD_ASSERT_NEXT(a_rec_moves, clk, rst, rec_valid && p_free, p_valid)
  `CO2SFD_ASSERT_IMPL(a_status_zero, clk, rst, result_valid && (frame_kind == KIND_STATUS),
                      co2_ppm == '0 && temperature_centi == '0 && humidity_centi == '0)
  `CO2SFD_ASSERT_IMPL(a_ready_needs_crc, clk, rst, result_valid && !crc_ok, !data_ready)
  `CO2SFD_ASSERT_IMPL(a_hum_range, clk, rst, result_valid, humidity_centi <= HUM_SCALE)

endmodule
